// ===== hw/rtl/gdi_pkg.sv =====
// package: sizes, command codes and the operand bundle of the interpolation unit
`default_nettype none

package gdi_pkg;

  localparam int ENERGY_POINTS = 32;
  localparam int ANGMOM_POINTS = 32;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int ROWIN_W = 5;
  localparam int COLIN_W = 5;

  localparam int ROW_W  = $clog2(ENERGY_POINTS);
  localparam int COL_W  = $clog2(ANGMOM_POINTS);
  localparam int CELLS  = ENERGY_POINTS * ANGMOM_POINTS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int IDX_W  = (ROW_W > COL_W) ? ROW_W : COL_W;

  localparam int OP_W   = DATA_W + 1;
  localparam int PROD_W = 2 * OP_W;
  localparam int CNT_W  = $clog2(OP_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_ENERGY = 2'd0,
    CMD_WRITE_ANGMOM = 2'd1,
    CMD_WRITE_DELTA  = 2'd2,
    CMD_QUERY        = 2'd3
  } cmd_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] x0;
    logic signed [DATA_W-1:0] x1;
    logic signed [DATA_W-1:0] y0;
    logic signed [DATA_W-1:0] y1;
  } lerp_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gdi_if.sv =====
// interfaces: command channel and result channel
`default_nettype none

interface gdi_cmd_if;
  logic                                valid;
  logic                                ready;
  gdi_pkg::cmd_e                       command;
  logic [gdi_pkg::ROWIN_W-1:0]         row_index;
  logic [gdi_pkg::COLIN_W-1:0]         col_index;
  logic signed [gdi_pkg::DATA_W-1:0]   write_value;
  logic signed [gdi_pkg::DATA_W-1:0]   query_energy;
  logic signed [gdi_pkg::DATA_W-1:0]   query_angmom;

  modport source (output valid, command, row_index, col_index, write_value,
                  query_energy, query_angmom, input ready);
  modport sink   (input valid, command, row_index, col_index, write_value,
                  query_energy, query_angmom, output ready);
endinterface

interface gdi_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [gdi_pkg::DATA_W-1:0]   delta_value;

  modport source (output valid, delta_value, input ready);
  modport sink   (input valid, delta_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gdi_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module gdi_ram #(
  parameter int   WIDTH = 32,
  parameter int   DEPTH = 32,
  localparam int  AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gdi_lerp.sv =====
// shared interpolation unit: shift-add multiply then restoring divide, one bit a cycle
`default_nettype none

module gdi_lerp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire gdi_pkg::lerp_req_t              req_i,
  output logic                                 done_o,
  output logic signed [gdi_pkg::DATA_W-1:0]    result_o
);

  import gdi_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_MUL  = 3'b010,
    L_DIV  = 3'b100
  } lstate_e;

  lstate_e                   state_q, state_d;
  logic [CNT_W-1:0]          cnt_q;
  logic [PROD_W-1:0]         mcand_q, acc_q, acc_nx;
  logic [OP_W-1:0]           mplier_q, den_q, low_q, quo_q;
  logic [OP_W:0]             rem_q, rem_sh, rem_sub;
  logic                      neg_q, qbit, last;
  logic signed [DATA_W-1:0]  y0_q;
  logic signed [OP_W-1:0]    den, num, dy;
  logic [OP_W-1:0]           numc, mag, qfin;
  logic signed [OP_W:0]      sum;

  assign den  = OP_W'(req_i.x1) - OP_W'(req_i.x0);
  assign num  = OP_W'(req_i.x)  - OP_W'(req_i.x0);
  assign dy   = OP_W'(req_i.y1) - OP_W'(req_i.y0);
  assign numc = num[OP_W-1] ? '0 : ((num > den) ? den : num);
  assign mag  = dy[OP_W-1] ? OP_W'(-dy) : OP_W'(dy);

  assign last    = (cnt_q == CNT_W'(OP_W - 1));
  assign acc_nx  = mplier_q[0] ? acc_q + mcand_q : acc_q;
  assign rem_sh  = {rem_q[OP_W-1:0], low_q[OP_W-1]};
  assign qbit    = (rem_sh >= {1'b0, den_q});
  assign rem_sub = qbit ? rem_sh - {1'b0, den_q} : rem_sh;
  assign qfin    = {quo_q[OP_W-2:0], qbit};
  assign sum     = neg_q ? (OP_W+1)'(y0_q) - (OP_W+1)'(qfin)
                         : (OP_W+1)'(y0_q) + (OP_W+1)'(qfin);

  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE: begin
        if (start_i && !(den[OP_W-1] || den == '0)) state_d = L_MUL;
      end
      L_MUL: begin
        if (last) state_d = L_DIV;
      end
      L_DIV: begin
        if (last) state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      case (state_q)
        L_IDLE: begin
          cnt_q <= '0;
          if (start_i && state_d == L_IDLE) done_o <= 1'b1;
        end
        L_MUL: begin
          cnt_q <= last ? '0 : cnt_q + 1'b1;
        end
        L_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (last) done_o <= 1'b1;
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          mcand_q  <= PROD_W'(mag);
          mplier_q <= numc;
          acc_q    <= '0;
          den_q    <= den;
          neg_q    <= dy[OP_W-1];
          y0_q     <= req_i.y0;
          quo_q    <= '0;
          result_o <= req_i.y0;
        end
      end
      L_MUL: begin
        acc_q    <= acc_nx;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        if (last) begin
          rem_q <= {1'b0, acc_nx[PROD_W-1:OP_W]};
          low_q <= acc_nx[OP_W-1:0];
        end
      end
      L_DIV: begin
        rem_q <= rem_sub;
        low_q <= low_q << 1;
        quo_q <= qfin;
        if (last) result_o <= sum[DATA_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_delta_interpolator.sv =====
// top level: grid tables, bracket search sequencer and result register
//
// channel  dir  payload                                          beat
// cmd_i    in   command row_index col_index write_value          valid & ready
//              query_energy query_angmom
// res_o    out  delta_value                                      valid & ready
//
// the length of a query is set by up to three linear scans of 32 entries on the read ports
// and up to three passes of the shared interpolation unit, each a multiply phase then a
// divide phase
// ready is low while a query is in flight; a finished result waits in its own register
// tables are not cleared by reset

`default_nettype none

module grid_delta_interpolator (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gdi_cmd_if.sink   cmd_i,
  gdi_res_if.source res_o
);

  import gdi_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ESCAN = 7'b0000010,
    S_RSCAN = 7'b0000100,
    S_DRD   = 7'b0001000,
    S_RLERP = 7'b0010000,
    S_ELERP = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e                    state_q;
  logic                      fire, row_ok, col_ok;
  logic                      e_we, a_we, d_we;
  logic [ROW_W-1:0]          e_waddr, e_raddr;
  logic [CELL_W-1:0]         c_waddr, a_raddr, d_raddr;
  logic [DATA_W-1:0]         e_rdata, a_rdata, d_rdata;

  logic signed [DATA_W-1:0]  qe_q, ql_q;
  logic [IDX_W-1:0]          idx_q, pidx_q, lo_q, last_idx;
  logic                      iss_q, pv_q, fin_q, hit_q, hit_now;
  logic signed [DATA_W-1:0]  sd, sx, g0_q, gn_q, glo_q, ghi_q;
  logic                      below, above;

  logic [ROW_W-1:0]          eb_q, et_q, rrow;
  logic                      eclamp_q, row_sel_q;
  logic signed [DATA_W-1:0]  ge0_q, ge1_q, d1_q, res_q, od_q;
  logic [COL_W-1:0]          lcol_q, dcol;
  logic                      lclamp_q;
  logic [1:0]                dcnt_q;
  logic signed [DATA_W-1:0]  da_q, row_val;
  logic                      row_done, start_row, start_e, ov_q, out_load;

  lerp_req_t                 lreq;
  logic                      l_done;
  logic signed [DATA_W-1:0]  l_result;

  // table writes
  assign cmd_i.ready = (state_q == S_IDLE);
  assign fire    = cmd_i.valid && cmd_i.ready;
  assign row_ok  = int'(cmd_i.row_index) < ENERGY_POINTS;
  assign col_ok  = int'(cmd_i.col_index) < ANGMOM_POINTS;
  assign e_we    = fire && row_ok && (cmd_i.command == CMD_WRITE_ENERGY);
  assign a_we    = fire && row_ok && col_ok && (cmd_i.command == CMD_WRITE_ANGMOM);
  assign d_we    = fire && row_ok && col_ok && (cmd_i.command == CMD_WRITE_DELTA);
  assign e_waddr = ROW_W'(cmd_i.row_index);
  assign c_waddr = CELL_W'(cmd_i.row_index) * CELL_W'(ANGMOM_POINTS)
                 + CELL_W'(cmd_i.col_index);

  // read addresses
  assign rrow    = row_sel_q ? et_q : eb_q;
  assign e_raddr = ROW_W'(idx_q);
  assign a_raddr = CELL_W'(rrow) * CELL_W'(ANGMOM_POINTS) + CELL_W'(idx_q);
  assign dcol    = (dcnt_q == 2'd0 || lclamp_q) ? lcol_q : lcol_q + 1'b1;
  assign d_raddr = CELL_W'(rrow) * CELL_W'(ANGMOM_POINTS) + CELL_W'(dcol);

  gdi_ram #(.WIDTH(DATA_W), .DEPTH(ENERGY_POINTS)) u_energy_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(cmd_i.write_value),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  gdi_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_angmom_ram (
    .clk_i, .we_i(a_we), .waddr_i(c_waddr), .wdata_i(cmd_i.write_value),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  gdi_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_delta_ram (
    .clk_i, .we_i(d_we), .waddr_i(c_waddr), .wdata_i(cmd_i.write_value),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  // scan datapath shared by energy and momentum searches
  assign last_idx = (state_q == S_ESCAN) ? IDX_W'(ENERGY_POINTS - 1)
                                         : IDX_W'(ANGMOM_POINTS - 1);
  assign sd       = (state_q == S_ESCAN) ? e_rdata : a_rdata;
  assign sx       = (state_q == S_ESCAN) ? qe_q : ql_q;
  assign hit_now  = (pidx_q != last_idx) && (sd <= sx);
  assign below    = sx < g0_q;
  assign above    = sx > gn_q;

  // row result and interpolation requests
  assign row_done  = (state_q == S_DRD && dcnt_q == 2'd2 && lclamp_q)
                  || (state_q == S_RLERP && l_done);
  assign row_val   = (state_q == S_RLERP) ? l_result : da_q;
  assign start_row = (state_q == S_DRD) && (dcnt_q == 2'd2) && !lclamp_q;
  assign start_e   = row_done && row_sel_q;

  always_comb begin
    if (start_e) begin
      lreq = '{x: qe_q, x0: ge0_q, x1: ge1_q, y0: d1_q, y1: row_val};
    end else begin
      lreq = '{x: ql_q, x0: glo_q, x1: ghi_q, y0: da_q, y1: d_rdata};
    end
  end

  gdi_lerp u_lerp (
    .clk_i, .rst_ni, .start_i(start_row || start_e), .req_i(lreq),
    .done_o(l_done), .result_o(l_result)
  );

  assign out_load = (state_q == S_OUT) && (!ov_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_q     <= 1'b0;
      pv_q      <= 1'b0;
      fin_q     <= 1'b0;
      dcnt_q    <= '0;
      row_sel_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      pv_q  <= iss_q;
      fin_q <= pv_q && (pidx_q == last_idx);
      if (iss_q && idx_q == last_idx) iss_q <= 1'b0;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (fire && cmd_i.command == CMD_QUERY) begin
            state_q   <= S_ESCAN;
            iss_q     <= 1'b1;
            row_sel_q <= 1'b0;
          end
        end
        S_ESCAN: begin
          if (fin_q) begin
            state_q <= S_RSCAN;
            iss_q   <= 1'b1;
          end
        end
        S_RSCAN: begin
          if (fin_q) begin
            state_q <= S_DRD;
            dcnt_q  <= '0;
          end
        end
        S_DRD: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 2'd2) begin
            if (!lclamp_q) begin
              state_q <= S_RLERP;
            end else if (row_sel_q) begin
              state_q <= S_ELERP;
            end else if (!eclamp_q) begin
              state_q   <= S_RSCAN;
              iss_q     <= 1'b1;
              row_sel_q <= 1'b1;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_RLERP: begin
          if (l_done) begin
            if (row_sel_q) begin
              state_q <= S_ELERP;
            end else if (!eclamp_q) begin
              state_q   <= S_RSCAN;
              iss_q     <= 1'b1;
              row_sel_q <= 1'b1;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_ELERP: begin
          if (l_done) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= idx_q;
    if (iss_q) idx_q <= idx_q + 1'b1;
    if (pv_q) begin
      if (pidx_q == '0)       g0_q  <= sd;
      if (pidx_q == last_idx) gn_q  <= sd;
      if (hit_q)              ghi_q <= sd;
      hit_q <= hit_now;
      if (hit_now) begin
        lo_q  <= pidx_q;
        glo_q <= sd;
      end
    end
    if (fire) begin
      qe_q <= cmd_i.query_energy;
      ql_q <= cmd_i.query_angmom;
    end
    if ((state_q == S_IDLE && fire) || (state_q == S_ESCAN && fin_q) || start_e
        || (state_q == S_RLERP && l_done && !row_sel_q)
        || (state_q == S_DRD && dcnt_q == 2'd2 && lclamp_q && !row_sel_q)) begin
      idx_q <= '0;
      hit_q <= 1'b0;
      lo_q  <= '0;
    end
    if (state_q == S_ESCAN && fin_q) begin
      eclamp_q <= below || above;
      ge0_q    <= glo_q;
      ge1_q    <= ghi_q;
      if (below) begin
        eb_q <= '0;
        et_q <= '0;
      end else if (above) begin
        eb_q <= ROW_W'(ENERGY_POINTS - 1);
        et_q <= ROW_W'(ENERGY_POINTS - 1);
      end else begin
        eb_q <= ROW_W'(lo_q);
        et_q <= ROW_W'(lo_q) + 1'b1;
      end
    end
    if (state_q == S_RSCAN && fin_q) begin
      lclamp_q <= below || above;
      if (below) begin
        lcol_q <= '0;
      end else if (above) begin
        lcol_q <= COL_W'(ANGMOM_POINTS - 1);
      end else begin
        lcol_q <= COL_W'(lo_q);
      end
    end
    if (state_q == S_DRD && dcnt_q == 2'd1) da_q <= d_rdata;
    if (row_done && !row_sel_q) begin
      d1_q  <= row_val;
      res_q <= row_val;
    end
    if (state_q == S_ELERP && l_done) res_q <= l_result;
    if (out_load) od_q <= res_q;
  end

  assign res_o.valid       = ov_q;
  assign res_o.delta_value = od_q;

endmodule

`default_nettype wire

// ===== verif/tb_grid_delta_interpolator.sv =====
// testbench: table loads, directed and random queries checked against an interpolation predictor or fixed values
module tb_grid_delta_interpolator;
  import gdi_pkg::*;

  localparam int  N_RANDOM = 1800;
  localparam int  N_QUIET  = 200;
  localparam longint LIMIT = 4_000_000;

  typedef struct {
    cmd_e                     cmd;
    logic [ROWIN_W-1:0]       row;
    logic [COLIN_W-1:0]       col;
    logic signed [DATA_W-1:0] wval;
    logic signed [DATA_W-1:0] en;
    logic signed [DATA_W-1:0] am;
    bit                       known;
    logic signed [DATA_W-1:0] want;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycle = 0;
  int errors = 0;
  bit quiet = 1'b0;
  int rd_stall = 0;

  logic signed [DATA_W-1:0] energy_tab [ENERGY_POINTS];
  logic signed [DATA_W-1:0] angmom_tab [ENERGY_POINTS][ANGMOM_POINTS];
  logic signed [DATA_W-1:0] delta_tab  [ENERGY_POINTS][ANGMOM_POINTS];
  logic signed [DATA_W-1:0] delta_due [$];

  gdi_cmd_if cmd ();
  gdi_res_if res ();

  grid_delta_interpolator DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd),
    .res_o (res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint lerp_q(longint x, longint x0, longint x1, longint y0,
                                    longint y1);
    longint den, num, dy;
    logic [127:0] prod;
    logic [63:0] mag, quo;
    den = x1 - x0;
    num = x - x0;
    dy  = y1 - y0;
    if (den <= 0) return y0;
    if (num < 0) num = 0;
    if (num > den) num = den;
    mag  = (dy < 0) ? -dy : dy;
    prod = 128'(num) * 128'(mag);
    quo  = 64'(prod / 128'(den));
    return (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
  endfunction

  function automatic int low_energy(longint x);
    int lo;
    lo = 0;
    for (int i = 0; i <= ENERGY_POINTS - 2; i++)
      if (longint'(energy_tab[i]) <= x) lo = i;
    return lo;
  endfunction

  function automatic longint row_delta(int r, longint l);
    int lo;
    lo = 0;
    if (l < longint'(angmom_tab[r][0])) return longint'(delta_tab[r][0]);
    if (l > longint'(angmom_tab[r][ANGMOM_POINTS-1]))
      return longint'(delta_tab[r][ANGMOM_POINTS-1]);
    for (int i = 0; i <= ANGMOM_POINTS - 2; i++)
      if (longint'(angmom_tab[r][i]) <= l) lo = i;
    return lerp_q(l, longint'(angmom_tab[r][lo]), longint'(angmom_tab[r][lo+1]),
                  longint'(delta_tab[r][lo]), longint'(delta_tab[r][lo+1]));
  endfunction

  function automatic logic signed [DATA_W-1:0] interp_delta(longint e, longint l);
    int eb, et;
    longint d1, d2;
    if (e < longint'(energy_tab[0])) begin
      eb = 0; et = 0;
    end else if (e > longint'(energy_tab[ENERGY_POINTS-1])) begin
      eb = ENERGY_POINTS - 1; et = ENERGY_POINTS - 1;
    end else begin
      eb = low_energy(e); et = eb + 1;
    end
    d1 = row_delta(eb, l);
    d2 = row_delta(et, l);
    if (eb != et)
      d1 = lerp_q(e, longint'(energy_tab[eb]), longint'(energy_tab[et]), d1, d2);
    return d1[DATA_W-1:0];
  endfunction

  function automatic void track(beat_t b);
    case (b.cmd)
      CMD_WRITE_ENERGY: energy_tab[b.row] = b.wval;
      CMD_WRITE_ANGMOM: angmom_tab[b.row][b.col] = b.wval;
      CMD_WRITE_DELTA:  delta_tab[b.row][b.col] = b.wval;
      default: begin
        if (b.known) delta_due.push_back(b.want);
        else delta_due.push_back(interp_delta(longint'(b.en), longint'(b.am)));
      end
    endcase
  endfunction

  task automatic send(beat_t b, int gap);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.command      <= b.cmd;
    cmd.row_index    <= b.row;
    cmd.col_index    <= b.col;
    cmd.write_value  <= b.wval;
    cmd.query_energy <= b.en;
    cmd.query_angmom <= b.am;
    do @(posedge clk); while (!cmd.ready);
    track(b);
  endtask

  function automatic beat_t mk(cmd_e c, int r, int cl, logic signed [31:0] w,
                               logic signed [31:0] e, logic signed [31:0] l,
                               bit k = 0, logic signed [31:0] wt = 0);
    beat_t b;
    b.cmd = c; b.row = ROWIN_W'(r); b.col = COLIN_W'(cl); b.wval = w; b.en = e;
    b.am = l;
    b.known = k; b.want = wt;
    return b;
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 11);
  endfunction

  // result side stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
      rd_stall  <= 0;
    end else if (quiet) begin
      res.ready <= 1'b1;
    end else if (rd_stall > 0) begin
      rd_stall  <= rd_stall - 1;
      res.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      rd_stall  <= $urandom_range(0, 10);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready) begin
      if (delta_due.size() == 0) begin
        $error("delta_value: none expected, actual %0d", res.delta_value);
        errors++;
      end else begin
        logic signed [DATA_W-1:0] w;
        w = delta_due.pop_front();
        if (res.delta_value !== w) begin
          $error("delta_value: expected %0d, actual %0d", w, res.delta_value);
          errors++;
        end
      end
    end
  end

  beat_t steps [$];

  initial begin
    beat_t b;
    logic signed [31:0] e, l, w;
    int r, c, waited;
    cmd.valid = 1'b0;
    cmd.command = CMD_WRITE_ENERGY;
    cmd.row_index = '0;
    cmd.col_index = '0;
    cmd.write_value = '0;
    cmd.query_energy = '0;
    cmd.query_angmom = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every entry before any query
    for (int i = 0; i < ENERGY_POINTS; i++)
      send(mk(CMD_WRITE_ENERGY, i, 0, (i - 16) <<< 20, 0, 0), pick_gap());
    for (int i = 0; i < ENERGY_POINTS; i++)
      for (int j = 0; j < ANGMOM_POINTS; j++) begin
        send(mk(CMD_WRITE_ANGMOM, i, j, j <<< 18, 0, 0), pick_gap());
        send(mk(CMD_WRITE_DELTA, i, j, (i * 32 + j) <<< 8, 0, 0), pick_gap());
      end

    steps.push_back(mk(CMD_QUERY, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 1, 0));
    steps.push_back(mk(CMD_QUERY, 31, 31, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 261888));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 1, 7936));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, -13 <<< 20, 5 <<< 18, 1, 25856));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, 32'sh0008_1234, 32'sh0012_3456));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, -(1 <<< 19), 32'sh0000_0001));
    // energy just above an extreme lower entry
    steps.push_back(mk(CMD_WRITE_ENERGY, 0, 0, 32'sh8000_0000, 0, 0));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, 32'sh8000_0001, 0));
    // zero denominator at the top of the energy grid
    steps.push_back(mk(CMD_WRITE_ENERGY, 30, 0, 15 <<< 20, 0, 0));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, 15 <<< 20, 7 <<< 18));
    // zero denominator at the top of a momentum row, then a wide top span in the next row
    steps.push_back(mk(CMD_WRITE_ANGMOM, 4, 30, 31 <<< 18, 0, 0));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, -12 <<< 20, 31 <<< 18));
    steps.push_back(mk(CMD_WRITE_ANGMOM, 5, 31, 32'sh7fff_ffff, 0, 0));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, -11 <<< 20, 32'sh7fff_fff0));
    // widest delta swing between neighbours
    steps.push_back(mk(CMD_WRITE_DELTA, 8, 10, 32'sh8000_0000, 0, 0));
    steps.push_back(mk(CMD_WRITE_DELTA, 8, 11, 32'sh7fff_ffff, 0, 0));
    steps.push_back(mk(CMD_WRITE_DELTA, 9, 10, 32'sh7fff_ffff, 0, 0));
    steps.push_back(mk(CMD_WRITE_DELTA, 9, 11, 32'sh8000_0000, 0, 0));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, (-8 <<< 20) + 32'sh0007_ffff,
                       (10 <<< 18) + 32'sh0001_5555));
    steps.push_back(mk(CMD_QUERY, 0, 0, 0, -8 <<< 20, (11 <<< 18) - 1));
    foreach (steps[k]) send(steps[k], pick_gap());

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= N_RANDOM - N_QUIET);
      if (n == N_RANDOM / 2) begin
        cmd.valid <= 1'b0;
        while (delta_due.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, ENERGY_POINTS - 1);
      c = $urandom_range(0, ANGMOM_POINTS - 1);
      w = $urandom_range(0, 9) == 0 ? $urandom : $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      case ($urandom_range(0, 9))
        0: b = mk(CMD_WRITE_ENERGY, r, c, $urandom_range(0, 9) == 0 ? w :
                  ((r - 16) <<< 20) + w, $urandom, $urandom);
        1: b = mk(CMD_WRITE_ANGMOM, r, c, $urandom_range(0, 9) == 0 ? w :
                  (c <<< 18) + (w >>> 2), $urandom, $urandom);
        2: b = mk(CMD_WRITE_DELTA, r, c, $urandom_range(0, 3) == 0 ? $urandom : w,
                  $urandom, $urandom);
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            e = $urandom; l = $urandom;
          end else begin
            e = $signed($urandom_range(0, 33 << 20)) - (17 <<< 20);
            l = $signed($urandom_range(0, 33 << 18)) - (1 <<< 18);
          end
          b = mk(CMD_QUERY, $urandom, $urandom, $urandom, e, l);
        end
      endcase
      send(b, pick_gap());
    end
    cmd.valid <= 1'b0;

    waited = 0;
    while (delta_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (500) @(posedge clk);
    if (errors == 0 && delta_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
